// File: design/glyph_font_rle_decoder_macros.svh
// ----------------------------------------------------------------------------
// Glyph font RLE decoder assertion macros
// Implication checks shared by the decoder's assertion section.
// ----------------------------------------------------------------------------
`ifndef GLYPH_FONT_RLE_DECODER_MACROS_SVH
`define GLYPH_FONT_RLE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GFRD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define GFRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: design/gfrd_pkg.sv
// ----------------------------------------------------------------------------
// Glyph font RLE decoder package
// Parser phases, result kinds, header magic and the result record.
// ----------------------------------------------------------------------------
package gfrd_pkg;

   localparam int unsigned COUNTER_W = 9;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_CONTROL = 3'd1,
      PH_LITERAL = 3'd2,
      PH_REPEAT  = 3'd3,
      PH_SKIP    = 3'd4,
      PH_HALT    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_RUN        = 2'd0,
      KIND_HEADER     = 2'd1,
      KIND_BAD_MAGIC  = 2'd2,
      KIND_ZERO_CELL  = 2'd3
   } kind_type;

   localparam logic [7:0] MAGIC_BYTES [4] = '{8'h46, 8'h4F, 8'h4E, 8'h31};
   localparam logic [7:0] CTRL_NOOP       = 8'h80;
   localparam logic [2:0] HDR_LAST_POS    = 3'd7;
   localparam logic [2:0] HDR_WIDTH_LO    = 3'd4;
   localparam logic [2:0] HDR_WIDTH_HI    = 3'd5;
   localparam logic [2:0] HDR_HEIGHT_LO   = 3'd6;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  pixel_value;
      logic [7:0]  run_length;
      logic [7:0]  glyph_index;
      logic [31:0] glyph_offset;
      logic        glyph_done;
      logic        font_done;
      logic [15:0] cell_width;
      logic [15:0] cell_height;
   } result_type;

endpackage

// File: design/glyph_font_rle_decoder.sv
// ----------------------------------------------------------------------------
// Glyph font RLE decoder
// Parses a bitmap font byte stream: header check, then PackBits glyph runs.
//
//   Channel  Ports                        Direction  Beat
//   req      req_valid/req_stall + fields in         one file byte
//   rsp      rsp_valid/rsp_stall + fields out        one run or header status
//
// One byte is taken every cycle unless a stalled result holds the input register;
// a beat's result is parsed from the input register into the result register.
// Reset is synchronous and returns the parser to the header phase.
// While a result is stalled, the input register still takes one more beat.
// ----------------------------------------------------------------------------
module glyph_font_rle_decoder #(
   parameter int unsigned GLYPH_COUNT = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_new_file,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_pixel_value,
   output logic [7:0]          rsp_run_length,
   output logic [7:0]          rsp_glyph_index,
   output logic [31:0]         rsp_glyph_offset,
   output logic                rsp_glyph_done,
   output logic                rsp_font_done,
   output logic [15:0]         rsp_cell_width,
   output logic [15:0]         rsp_cell_height
);
   import gfrd_pkg::*;
   `include "glyph_font_rle_decoder_macros.svh"

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_new_ff;
   logic        out_block;
   logic        step;
   logic        accept;
   result_type  result;
   result_type  rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   assign out_block = rsp_valid_ff && rsp_stall;
   assign step      = in_valid_ff && !out_block;
   assign req_stall = in_valid_ff && out_block;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (step) begin
         rsp_valid_in = result.valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   gfrd_parser #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .new_file  (in_new_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_new_ff  <= req_new_file;
      end
      if (step && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_pixel_value  = rsp_ff.pixel_value;
   assign rsp_run_length   = rsp_ff.run_length;
   assign rsp_glyph_index  = rsp_ff.glyph_index;
   assign rsp_glyph_offset = rsp_ff.glyph_offset;
   assign rsp_glyph_done   = rsp_ff.glyph_done;
   assign rsp_font_done    = rsp_ff.font_done;
   assign rsp_cell_width   = rsp_ff.cell_width;
   assign rsp_cell_height  = rsp_ff.cell_height;

   `GFRD_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      rsp_valid && rsp_stall)
   `GFRD_ASSERT_NOW(a_run_length_range, clock, reset, rsp_valid && rsp_kind == KIND_RUN,
      rsp_run_length != 8'd0 && rsp_run_length <= 8'd128)
   `GFRD_ASSERT_NOW(a_status_no_run, clock, reset, rsp_valid && rsp_kind != KIND_RUN,
      rsp_run_length == 8'd0 && !rsp_glyph_done)
   `GFRD_ASSERT_NOW(a_font_done_glyph, clock, reset, rsp_valid && rsp_font_done,
      rsp_glyph_done)
   `GFRD_ASSERT_NEXT(a_held_beat_moves, clock, reset, req_stall && !rsp_stall,
      !req_stall)

endmodule

// File: design/gfrd_parser.sv
// ----------------------------------------------------------------------------
// Glyph font RLE decoder parser
// Holds the parse state and turns one file byte into at most one result.
// ----------------------------------------------------------------------------
module gfrd_parser #(
   parameter int unsigned GLYPH_COUNT = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                new_file,
   output gfrd_pkg::result_type result
);
   import gfrd_pkg::*;

   phase_type              phase_ff, phase_in, phase_eff;
   logic [2:0]             pos_ff, pos_in, pos_eff;
   logic [15:0]            width_ff, width_in, width_eff;
   logic [15:0]            height_ff, height_in, height_eff;
   logic [31:0]            pixels_ff, pixels_in, pixels_eff;
   logic [31:0]            remaining_ff, remaining_in, remaining_eff;
   logic [COUNTER_W-1:0]   counter_ff, counter_in, counter_eff;
   logic [7:0]             pending_ff, pending_in, pending_eff;

   logic [7:0]             want;
   logic                   gdone;
   logic                   fdone;
   logic [7:0]             run_len;
   logic [COUNTER_W-1:0]   counter_plus;
   logic [7:0]             pending_dec;
   logic                   magic_bad;
   logic [15:0]            height_full;
   logic [31:0]            product;
   logic                   cell_zero;

   // A beat with new_file set sees the reset state.
   assign phase_eff     = new_file ? PH_HEADER : phase_ff;
   assign pos_eff       = new_file ? '0 : pos_ff;
   assign width_eff     = new_file ? '0 : width_ff;
   assign height_eff    = new_file ? '0 : height_ff;
   assign pixels_eff    = new_file ? '0 : pixels_ff;
   assign remaining_eff = new_file ? '0 : remaining_ff;
   assign counter_eff   = new_file ? '0 : counter_ff;
   assign pending_eff   = new_file ? '0 : pending_ff;

   assign want         = (phase_eff == PH_REPEAT) ? pending_eff : 8'd1;
   assign gdone        = {24'd0, want} >= remaining_eff;
   assign run_len      = gdone ? remaining_eff[7:0] : want;
   assign counter_plus = counter_eff + COUNTER_W'(1);
   assign fdone        = gdone && (counter_plus >= COUNTER_W'(GLYPH_COUNT));
   assign pending_dec  = pending_eff - 8'd1;
   assign magic_bad    = (pos_eff[2] == 1'b0) && (data_byte != MAGIC_BYTES[pos_eff[1:0]]);
   assign height_full  = {data_byte, height_eff[7:0]};
   assign product      = {16'd0, width_eff} * {16'd0, height_full};
   assign cell_zero    = (width_eff == 16'd0) || (height_full == 16'd0);

   always_comb begin
      unique case (phase_eff)
         PH_HEADER: begin
            if (magic_bad) begin
               phase_in = PH_HALT;
            end else if (pos_eff == HDR_LAST_POS) begin
               phase_in = cell_zero ? PH_HALT : PH_CONTROL;
            end else begin
               phase_in = PH_HEADER;
            end
         end
         PH_CONTROL: begin
            if (data_byte[7] == 1'b0) begin
               phase_in = PH_LITERAL;
            end else if (data_byte != CTRL_NOOP) begin
               phase_in = PH_REPEAT;
            end else begin
               phase_in = PH_CONTROL;
            end
         end
         PH_LITERAL: begin
            priority if (fdone) begin
               phase_in = PH_HALT;
            end else if (pending_dec == 8'd0) begin
               phase_in = PH_CONTROL;
            end else if (gdone) begin
               phase_in = PH_SKIP;
            end else begin
               phase_in = PH_LITERAL;
            end
         end
         PH_REPEAT: begin
            phase_in = fdone ? PH_HALT : PH_CONTROL;
         end
         PH_SKIP: begin
            phase_in = (pending_dec == 8'd0) ? PH_CONTROL : PH_SKIP;
         end
         PH_HALT: begin
            phase_in = PH_HALT;
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase
   end

   always_comb begin
      pos_in       = pos_eff;
      width_in     = width_eff;
      height_in    = height_eff;
      pixels_in    = pixels_eff;
      remaining_in = remaining_eff;
      counter_in   = counter_eff;
      pending_in   = pending_eff;
      result       = '0;
      unique case (phase_eff)
         PH_HEADER: begin
            if (magic_bad) begin
               result.valid = 1'b1;
               result.kind  = KIND_BAD_MAGIC;
            end else if (pos_eff == HDR_LAST_POS) begin
               height_in          = height_full;
               result.valid       = 1'b1;
               result.cell_width  = width_eff;
               result.cell_height = height_full;
               if (cell_zero) begin
                  result.kind = KIND_ZERO_CELL;
               end else begin
                  result.kind  = KIND_HEADER;
                  pixels_in    = product;
                  remaining_in = product;
                  counter_in   = '0;
               end
            end else begin
               pos_in = pos_eff + 3'd1;
               if (pos_eff == HDR_WIDTH_LO) begin
                  width_in = {8'd0, data_byte};
               end else if (pos_eff == HDR_WIDTH_HI) begin
                  width_in = {data_byte, width_eff[7:0]};
               end else if (pos_eff == HDR_HEIGHT_LO) begin
                  height_in = {8'd0, data_byte};
               end
            end
         end
         PH_CONTROL: begin
            if (data_byte[7] == 1'b0) begin
               pending_in = data_byte + 8'd1;
            end else if (data_byte != CTRL_NOOP) begin
               pending_in = (8'd0 - data_byte) + 8'd1;
            end
         end
         PH_LITERAL, PH_REPEAT: begin
            result.valid        = 1'b1;
            result.kind         = KIND_RUN;
            result.pixel_value  = data_byte;
            result.run_length   = run_len;
            result.glyph_index  = counter_eff[7:0];
            result.glyph_offset = pixels_eff - remaining_eff;
            result.glyph_done   = gdone;
            result.font_done    = fdone;
            pending_in          = (phase_eff == PH_LITERAL) ? pending_dec : 8'd0;
            if (gdone) begin
               counter_in   = counter_plus;
               remaining_in = pixels_eff;
            end else begin
               remaining_in = remaining_eff - {24'd0, run_len};
            end
         end
         PH_SKIP: begin
            pending_in = pending_dec;
         end
         PH_HALT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         pixels_ff    <= '0;
         remaining_ff <= '0;
         counter_ff   <= '0;
         pending_ff   <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pixels_ff    <= pixels_in;
         remaining_ff <= remaining_in;
         counter_ff   <= counter_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

// File: tb/glyph_font_rle_decoder_test.sv
// ----------------------------------------------------------------------------
// Glyph font RLE decoder testbench
// Feeds font files one byte per beat: a short scripted file set, then random
// files that are mostly well formed with random PackBits bodies, one whole
// font, and some noise and broken headers. Every result beat is compared
// with a decoder model kept in this file, under four idle and stall mixes
// and one long receiver hold.
// ----------------------------------------------------------------------------
module glyph_font_rle_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gfrd_pkg::*;

   localparam int         GLYPHS       = 256;
   localparam int         RANDOM_BYTES = 1950;
   localparam int         QUIET_LIMIT  = 2000;
   localparam int         HOLD_CYCLES  = 80;
   localparam int         TAIL_CYCLES  = 16;
   localparam int         SCRIPT_LEN   = 27;
   localparam logic [7:0] LIT_MAX      = 8'h7F;
   localparam logic [7:0] REPEAT_MIN   = 8'h81;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  pixel_value;
      logic [7:0]  run_length;
      logic [7:0]  glyph_index;
      logic [31:0] glyph_offset;
      logic        glyph_done;
      logic        font_done;
      logic [15:0] cell_width;
      logic [15:0] cell_height;
   } font_result_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        opens_file;
      logic        typed;
      kind_type    kind;
      logic [15:0] width;
      logic [15:0] height;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_new_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_pixel_value;
   logic [7:0]  rsp_run_length;
   logic [7:0]  rsp_glyph_index;
   logic [31:0] rsp_glyph_offset;
   logic        rsp_glyph_done;
   logic        rsp_font_done;
   logic [15:0] rsp_cell_width;
   logic [15:0] rsp_cell_height;

   font_result_type predicted_results[$];
   font_result_type oldest_result;

   phase_type   dec_phase;
   logic [2:0]  dec_hdr_pos;
   logic [15:0] dec_width;
   logic [15:0] dec_height;
   logic [31:0] dec_glyph_pixels;
   logic [31:0] dec_glyph_left;
   logic [8:0]  dec_glyph_num;
   logic [7:0]  dec_run_left;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   bit   hold_request = 1'b0;
   logic long_hold = 1'b0;
   int   quiet_cycles = 0;
   int   mismatches = 0;
   int   bytes_sent = 0;
   int   results_seen = 0;
   int   headers_seen = 0;
   int   errors_seen = 0;
   int   fonts_seen = 0;

   script_row_type script [SCRIPT_LEN] = '{
      '{MAGIC_BYTES[0], 1'b1, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{MAGIC_BYTES[1], 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{MAGIC_BYTES[2], 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{MAGIC_BYTES[3], 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h02, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h01, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b1, KIND_HEADER, 16'h0002, 16'h0001},
      '{CTRL_NOOP, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h01, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{REPEAT_MIN, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'hAA, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h02, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h12, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h34, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h56, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h00, 1'b1, 1'b1, KIND_BAD_MAGIC, 16'h0000, 16'h0000},
      '{MAGIC_BYTES[0], 1'b1, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{MAGIC_BYTES[1], 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{MAGIC_BYTES[2], 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{MAGIC_BYTES[3], 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b0, KIND_RUN, 16'h0000, 16'h0000},
      '{8'h00, 1'b0, 1'b1, KIND_ZERO_CELL, 16'hFFFF, 16'h0000}
   };

   glyph_font_rle_decoder #(.GLYPH_COUNT(GLYPHS)) DUT (.*);

   always #1 clock = ~clock;

   function automatic void restart_decoder();
      dec_phase        = PH_HEADER;
      dec_hdr_pos      = 3'd0;
      dec_width        = 16'd0;
      dec_height       = 16'd0;
      dec_glyph_pixels = 32'd0;
      dec_glyph_left   = 32'd0;
      dec_glyph_num    = 9'd0;
      dec_run_left     = 8'd0;
   endfunction

   function automatic font_result_type clip_run(input logic [7:0] value,
                                                input logic [7:0] want);
      font_result_type res;
      logic [31:0]     len;
      res              = '0;
      len              = {24'd0, want};
      res.kind         = KIND_RUN;
      res.pixel_value  = value;
      res.glyph_index  = dec_glyph_num[7:0];
      res.glyph_offset = dec_glyph_pixels - dec_glyph_left;
      if (len >= dec_glyph_left) begin
         len            = dec_glyph_left;
         res.glyph_done = 1'b1;
      end
      res.run_length = len[7:0];
      dec_glyph_left = dec_glyph_left - len;
      if (res.glyph_done) begin
         dec_glyph_num  = dec_glyph_num + 9'd1;
         dec_glyph_left = dec_glyph_pixels;
         res.font_done  = (dec_glyph_num >= GLYPHS);
      end
      return res;
   endfunction

   function automatic bit parse_font_byte(input logic [7:0] b, input logic opens_file,
                                          output font_result_type res);
      logic [8:0] repeat_len;
      res = '0;
      if (opens_file) restart_decoder();
      case (dec_phase)
         PH_HEADER: begin
            if (dec_hdr_pos < HDR_WIDTH_LO) begin
               if (b != MAGIC_BYTES[dec_hdr_pos[1:0]]) begin
                  res.kind  = KIND_BAD_MAGIC;
                  dec_phase = PH_HALT;
                  return 1'b1;
               end
            end else if (dec_hdr_pos == HDR_WIDTH_LO) begin
               dec_width = {8'h00, b};
            end else if (dec_hdr_pos == HDR_WIDTH_HI) begin
               dec_width[15:8] = b;
            end else if (dec_hdr_pos == HDR_HEIGHT_LO) begin
               dec_height = {8'h00, b};
            end else begin
               dec_height[15:8] = b;
               res.cell_width   = dec_width;
               res.cell_height  = dec_height;
               if (dec_width == 16'd0 || dec_height == 16'd0) begin
                  res.kind  = KIND_ZERO_CELL;
                  dec_phase = PH_HALT;
                  return 1'b1;
               end
               dec_glyph_pixels = {16'd0, dec_width} * {16'd0, dec_height};
               dec_glyph_left   = dec_glyph_pixels;
               dec_glyph_num    = 9'd0;
               dec_phase        = PH_CONTROL;
               res.kind         = KIND_HEADER;
               return 1'b1;
            end
            dec_hdr_pos = dec_hdr_pos + 3'd1;
            return 1'b0;
         end
         PH_CONTROL: begin
            if (b <= LIT_MAX) begin
               dec_run_left = b + 8'd1;
               dec_phase    = PH_LITERAL;
            end else if (b != CTRL_NOOP) begin
               repeat_len   = 9'd257 - {1'b0, b};
               dec_run_left = repeat_len[7:0];
               dec_phase    = PH_REPEAT;
            end
            return 1'b0;
         end
         PH_LITERAL: begin
            res          = clip_run(b, 8'd1);
            dec_run_left = dec_run_left - 8'd1;
            if (res.font_done) dec_phase = PH_HALT;
            else if (dec_run_left == 8'd0) dec_phase = PH_CONTROL;
            else if (res.glyph_done) dec_phase = PH_SKIP;
            return 1'b1;
         end
         PH_REPEAT: begin
            res          = clip_run(b, dec_run_left);
            dec_run_left = 8'd0;
            dec_phase    = res.font_done ? PH_HALT : PH_CONTROL;
            return 1'b1;
         end
         PH_SKIP: begin
            dec_run_left = dec_run_left - 8'd1;
            if (dec_run_left == 8'd0) dec_phase = PH_CONTROL;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic opens_file,
                            input logic typed, input font_result_type typed_res);
      font_result_type res;
      bit              has_res;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_new_file  <= opens_file;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has_res = parse_font_byte(b, opens_file, res);
      if (typed) begin
         res     = typed_res;
         has_res = 1'b1;
      end
      if (has_res) predicted_results.push_back(res);
      bytes_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_font_file(input bit whole_font);
      int unsigned pick;
      int unsigned budget;
      int unsigned body;
      int unsigned n;
      int unsigned k;
      logic [15:0] w;
      logic [15:0] h;
      logic [7:0]  b;
      pick = whole_font ? 99 : $urandom_range(0, 99);
      if (pick < 10) begin
         n = $urandom_range(1, 12);
         for (k = 0; k < n; k++) begin
            b = 8'($urandom);
            send_byte(b, k == 0 || $urandom_range(0, 15) == 0, 1'b0, '0);
         end
         return;
      end
      if (pick < 20) begin
         n = $urandom_range(0, 3);
         for (k = 0; k < n; k++) send_byte(MAGIC_BYTES[k[1:0]], k == 0, 1'b0, '0);
         b = 8'($urandom_range(1, 255));
         send_byte(MAGIC_BYTES[n[1:0]] ^ b, n == 0, 1'b0, '0);
         for (k = $urandom_range(0, 3); k > 0; k--) begin
            b = 8'($urandom);
            send_byte(b, 1'b0, 1'b0, '0);
         end
         return;
      end
      for (k = 0; k < 4; k++) send_byte(MAGIC_BYTES[k[1:0]], k == 0, 1'b0, '0);
      if (whole_font) begin
         w = 16'd1;
         h = 16'd1;
      end else if (pick < 28) begin
         w = 16'($urandom);
         h = 16'($urandom);
         case ($urandom_range(0, 2))
            0: w = 16'd0;
            1: h = 16'd0;
            default: begin
               w = 16'd0;
               h = 16'd0;
            end
         endcase
      end else if (pick < 80) begin
         w = 16'($urandom_range(1, 4));
         h = 16'($urandom_range(1, 4));
      end else if (pick < 95) begin
         w = 16'($urandom_range(1, 64));
         h = 16'($urandom_range(1, 16));
      end else if (pick < 97) begin
         w = 16'hFFFF;
         h = 16'hFFFF;
      end else begin
         w = 16'($urandom_range(1, 65535));
         h = 16'($urandom_range(1, 65535));
      end
      send_byte(w[7:0], 1'b0, 1'b0, '0);
      send_byte(w[15:8], 1'b0, 1'b0, '0);
      send_byte(h[7:0], 1'b0, 1'b0, '0);
      send_byte(h[15:8], 1'b0, 1'b0, '0);
      budget = whole_font ? 4000 : $urandom_range(4, 90);
      body   = 0;
      while (body < budget && dec_phase != PH_HALT) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if (whole_font) n = $urandom_range(0, 1);
            else if ($urandom_range(0, 9) == 0) n = $urandom_range(0, LIT_MAX);
            else n = $urandom_range(0, 7);
            send_byte(n[7:0], 1'b0, 1'b0, '0);
            body++;
            for (k = 0; k <= n && dec_phase != PH_HALT; k++) begin
               b = 8'($urandom);
               send_byte(b, 1'b0, 1'b0, '0);
               body++;
            end
         end else if (pick < 93) begin
            b = 8'($urandom_range(REPEAT_MIN, 255));
            send_byte(b, 1'b0, 1'b0, '0);
            b = 8'($urandom);
            send_byte(b, 1'b0, 1'b0, '0);
            body += 2;
         end else begin
            send_byte(CTRL_NOOP, 1'b0, 1'b0, '0);
            body++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
   endtask

   always @(negedge clock) begin
      rsp_stall <= long_hold || ($urandom_range(0, 99) < stall_pct);
   end

   initial begin : receiver_hold
      wait (hold_request);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (predicted_results.size() == 0) begin
            report_mismatch("result beat with nothing pending, kind", 32'(rsp_kind), 32'd0);
         end else begin
            oldest_result = predicted_results.pop_front();
            if (oldest_result.kind == KIND_HEADER) headers_seen++;
            if (oldest_result.kind == KIND_BAD_MAGIC || oldest_result.kind == KIND_ZERO_CELL)
               errors_seen++;
            if (oldest_result.font_done) fonts_seen++;
            if (rsp_kind !== oldest_result.kind)
               report_mismatch("kind", 32'(rsp_kind), 32'(oldest_result.kind));
            if (rsp_pixel_value !== oldest_result.pixel_value)
               report_mismatch("pixel_value", 32'(rsp_pixel_value),
                               32'(oldest_result.pixel_value));
            if (rsp_run_length !== oldest_result.run_length)
               report_mismatch("run_length", 32'(rsp_run_length),
                               32'(oldest_result.run_length));
            if (rsp_glyph_index !== oldest_result.glyph_index)
               report_mismatch("glyph_index", 32'(rsp_glyph_index),
                               32'(oldest_result.glyph_index));
            if (rsp_glyph_offset !== oldest_result.glyph_offset)
               report_mismatch("glyph_offset", rsp_glyph_offset, oldest_result.glyph_offset);
            if (rsp_glyph_done !== oldest_result.glyph_done)
               report_mismatch("glyph_done", 32'(rsp_glyph_done),
                               32'(oldest_result.glyph_done));
            if (rsp_font_done !== oldest_result.font_done)
               report_mismatch("font_done", 32'(rsp_font_done),
                               32'(oldest_result.font_done));
            if (rsp_cell_width !== oldest_result.cell_width)
               report_mismatch("cell_width", 32'(rsp_cell_width),
                               32'(oldest_result.cell_width));
            if (rsp_cell_height !== oldest_result.cell_height)
               report_mismatch("cell_height", 32'(rsp_cell_height),
                               32'(oldest_result.cell_height));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("FAIL glyph_font_rle_decoder");
            $finish;
         end
      end
   end

   initial begin : stimulus
      font_result_type typed_res;
      int              stage;
      int              stage_end;
      restart_decoder();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         typed_res             = '0;
         typed_res.kind        = script[i].kind;
         typed_res.cell_width  = script[i].width;
         typed_res.cell_height = script[i].height;
         send_byte(script[i].data, script[i].opens_file, script[i].typed, typed_res);
      end
      drain_results();

      for (stage = 0; stage < 4; stage++) begin
         case (stage)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               hold_request  = 1'b1;
            end
            1: begin
               send_idle_pct = 70;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 70;
            end
            default: begin
               send_idle_pct = 25;
               stall_pct     = 25;
            end
         endcase
         stage_end = SCRIPT_LEN + (stage + 1) * (RANDOM_BYTES / 4);
         if (stage == 0) send_font_file(1'b1);
         while (bytes_sent < stage_end) send_font_file(1'b0);
         drain_results();
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d input beats and %0d result beats", bytes_sent, results_seen);
      $display("%0d headers accepted, %0d header errors, %0d complete fonts, %0d mismatches",
               headers_seen, errors_seen, fonts_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS glyph_font_rle_decoder");
      end else begin
         $display("FAIL glyph_font_rle_decoder");
      end
      $finish;
   end

endmodule
